FILE: hw/rtl/cel_pkg.sv
// Shared types and constants for the compacting entry list.
package cel_pkg;

    // Default sizes
    localparam int CEL_DEPTH    = 64;
    localparam int CEL_TAG_BITS = 16;
    localparam int CEL_ID_BITS  = 16;

    // Action codes carried in the request word
    typedef enum logic [2:0] {
        ACT_APPEND     = 3'd0,
        ACT_REMOVE_POS = 3'd1,
        ACT_REMOVE_TAG = 3'd2,
        ACT_REMOVE_KEY = 3'd3,
        ACT_READ       = 3'd4,
        ACT_CLEAR      = 3'd5
    } action_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Request word
    typedef struct packed {
        logic [2:0]  action;
        logic [5:0]  position;
        logic [15:0] tag;
        logic [3:0]  list_number;
        logic [15:0] item_id;
    } in_word_t;

    // Response word
    typedef struct packed {
        logic        ok;
        logic [6:0]  entry_count;
        logic [5:0]  hit_position;
        logic [15:0] read_tag;
        logic [3:0]  read_list_number;
        logic [15:0] read_item_id;
    } out_word_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic [2:0] action;
        logic       shift;
        logic       write;
    } cel_ctl_t;

endpackage

FILE: hw/rtl/compacting_entry_list_top.sv
// Top level of the compacting entry list: sequencer and a row of DEPTH cells.
//
// Request words enter on req/req_valid/req_ready, response words leave on
// rsp/rsp_valid/rsp_ready; a word moves when valid and ready are both high.
// Every request word yields exactly one response word, in order.
// Sequencing:
//   Append, clear and unused codes: the request goes straight to the done
//   state; the next request is taken only after the response is registered.
//   Remove by position, tag or key, and read: a scan state comes first, in
//   which the hit carry walks one cell per cycle from the top of the row
//   down to cell zero, so that the lowest matching entry wins. The next
//   request is taken only after the response is registered. Removal closes
//   the gap: the hit cell and every cell above it load from the cell above.
// Reset: the list comes up empty and no response is pending; entry storage
//   is not cleared and is never read above the entry count.
// Stall: a finished response sits in the output register while rsp_ready is
//   low; one more request may be accepted meanwhile, and its result waits
//   until the output register frees up.
module compacting_entry_list_top
    import cel_pkg::*;
#(
    parameter int DEPTH    = CEL_DEPTH,
    parameter int TAG_BITS = CEL_TAG_BITS,
    parameter int ID_BITS  = CEL_ID_BITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  in_word_t  req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output out_word_t rsp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cel_ctl_t            ctl;
    logic [CNT_W-1:0]    count;
    logic [IDX_W-1:0]    shift_idx;
    logic [5:0]          pos;
    logic [TAG_BITS-1:0] key_tag;
    logic [3:0]          key_list;
    logic [ID_BITS-1:0]  key_id;

    // Entries per cell
    logic [TAG_BITS-1:0] ent_tag  [DEPTH];
    logic [3:0]          ent_list [DEPTH];
    logic [ID_BITS-1:0]  ent_id   [DEPTH];

    // Carry chain, one extra slot above the top cell
    logic                car_found [DEPTH+1];
    logic [IDX_W-1:0]    car_idx   [DEPTH+1];
    logic [TAG_BITS-1:0] car_tag   [DEPTH+1];
    logic [3:0]          car_list  [DEPTH+1];
    logic [ID_BITS-1:0]  car_id    [DEPTH+1];

    // Nothing enters the chain from above
    assign car_found[DEPTH] = 1'b0;
    assign car_idx[DEPTH]   = '0;
    assign car_tag[DEPTH]   = '0;
    assign car_list[DEPTH]  = '0;
    assign car_id[DEPTH]    = '0;

    cel_ctrl #(
        .DEPTH    (DEPTH),
        .TAG_BITS (TAG_BITS),
        .ID_BITS  (ID_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .ctl       (ctl),
        .count     (count),
        .shift_idx (shift_idx),
        .pos       (pos),
        .key_tag   (key_tag),
        .key_list  (key_list),
        .key_id    (key_id),
        .hit_found (car_found[0]),
        .hit_idx   (car_idx[0]),
        .hit_tag   (car_tag[0]),
        .hit_list  (car_list[0]),
        .hit_id    (car_id[0])
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam int UP = (i == DEPTH - 1) ? i : i + 1;

        cel_cell #(
            .DEPTH    (DEPTH),
            .TAG_BITS (TAG_BITS),
            .ID_BITS  (ID_BITS),
            .IDX      (i)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .count       (count),
            .shift_idx   (shift_idx),
            .pos         (pos),
            .key_tag     (key_tag),
            .key_list    (key_list),
            .key_id      (key_id),
            .up_tag      (ent_tag[UP]),
            .up_list     (ent_list[UP]),
            .up_id       (ent_id[UP]),
            .up_found    (car_found[i+1]),
            .up_idx      (car_idx[i+1]),
            .up_car_tag  (car_tag[i+1]),
            .up_car_list (car_list[i+1]),
            .up_car_id   (car_id[i+1]),
            .tag         (ent_tag[i]),
            .list_number (ent_list[i]),
            .item_id     (ent_id[i]),
            .found       (car_found[i]),
            .idx         (car_idx[i]),
            .car_tag     (car_tag[i]),
            .car_list    (car_list[i]),
            .car_id      (car_id[i])
        );
    end

endmodule

FILE: hw/rtl/cel_cell.sv
// One list cell: holds one entry and one stage of the downward hit carry.
module cel_cell
    import cel_pkg::*;
#(
    parameter int DEPTH    = CEL_DEPTH,
    parameter int TAG_BITS = CEL_TAG_BITS,
    parameter int ID_BITS  = CEL_ID_BITS,
    parameter int IDX      = 0
)
(
    input  logic                             clk,
    input  cel_ctl_t                         ctl,
    input  logic [$clog2(DEPTH+1)-1:0]       count,
    input  logic [$clog2(DEPTH)-1:0]         shift_idx,
    input  logic [5:0]                       pos,
    input  logic [TAG_BITS-1:0]              key_tag,
    input  logic [3:0]                       key_list,
    input  logic [ID_BITS-1:0]               key_id,
    // entry of the next higher cell
    input  logic [TAG_BITS-1:0]              up_tag,
    input  logic [3:0]                       up_list,
    input  logic [ID_BITS-1:0]               up_id,
    // carry from the next higher cell
    input  logic                             up_found,
    input  logic [$clog2(DEPTH)-1:0]         up_idx,
    input  logic [TAG_BITS-1:0]              up_car_tag,
    input  logic [3:0]                       up_car_list,
    input  logic [ID_BITS-1:0]               up_car_id,
    // own entry
    output logic [TAG_BITS-1:0]              tag,
    output logic [3:0]                       list_number,
    output logic [ID_BITS-1:0]               item_id,
    // own carry
    output logic                             found,
    output logic [$clog2(DEPTH)-1:0]         idx,
    output logic [TAG_BITS-1:0]              car_tag,
    output logic [3:0]                       car_list,
    output logic [ID_BITS-1:0]               car_id
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (IDX_W > 6) ? IDX_W : 6;
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);
    localparam logic [CMP_W-1:0] MY_CMP = CMP_W'(IDX);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [TAG_BITS-1:0] tag_reg,  tag_next;
    logic [3:0]          list_reg, list_next;
    logic [ID_BITS-1:0]  id_reg,   id_next;

    logic                found_reg,   found_next;
    logic [IDX_W-1:0]    idx_reg,     idx_next;
    logic [TAG_BITS-1:0] car_tag_reg, car_tag_next;
    logic [3:0]          car_list_reg, car_list_next;
    logic [ID_BITS-1:0]  car_id_reg,  car_id_next;

    logic valid;
    logic match;
    logic hit;

    // Flag a live entry (index below the entry count) and whether it meets the search
    assign valid = (MY_CNT < count);

    always_comb
    begin
        case (ctl.action) inside
            ACT_REMOVE_POS, ACT_READ: match = (MY_CMP == CMP_W'(pos));
            ACT_REMOVE_TAG:           match = (tag_reg == key_tag);
            ACT_REMOVE_KEY:           match = (list_reg == key_list) && (id_reg == key_id);
            default:                  match = 1'b0;
        endcase
    end

    assign hit = valid && match;

    // Append at the tail, or close the gap left by a removal
    always_comb
    begin
        tag_next  = tag_reg;
        list_next = list_reg;
        id_next   = id_reg;
        if (ctl.write && (MY_CNT == count))
        begin
            tag_next  = key_tag;
            list_next = key_list;
            id_next   = key_id;
        end
        else if (ctl.shift && (MY_IDX >= shift_idx))
        begin
            tag_next  = up_tag;
            list_next = up_list;
            id_next   = up_id;
        end
    end

    // Pass the lowest hit seen so far down toward cell zero
    always_comb
    begin
        if (hit)
        begin
            found_next    = 1'b1;
            idx_next      = MY_IDX;
            car_tag_next  = tag_reg;
            car_list_next = list_reg;
            car_id_next   = id_reg;
        end
        else
        begin
            found_next    = up_found;
            idx_next      = up_idx;
            car_tag_next  = up_car_tag;
            car_list_next = up_car_list;
            car_id_next   = up_car_id;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg      <= tag_next;
        list_reg     <= list_next;
        id_reg       <= id_next;
        found_reg    <= found_next;
        idx_reg      <= idx_next;
        car_tag_reg  <= car_tag_next;
        car_list_reg <= car_list_next;
        car_id_reg   <= car_id_next;
    end

    assign tag         = tag_reg;
    assign list_number = list_reg;
    assign item_id     = id_reg;
    assign found       = found_reg;
    assign idx         = idx_reg;
    assign car_tag     = car_tag_reg;
    assign car_list    = car_list_reg;
    assign car_id      = car_id_reg;

endmodule

FILE: hw/rtl/cel_ctrl.sv
// Sequencer: takes request words, times the cell scan, applies updates, holds the response.
module cel_ctrl
    import cel_pkg::*;
#(
    parameter int DEPTH    = CEL_DEPTH,
    parameter int TAG_BITS = CEL_TAG_BITS,
    parameter int ID_BITS  = CEL_ID_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  in_word_t                     req,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output out_word_t                    rsp,
    // to the cells
    output cel_ctl_t                     ctl,
    output logic [$clog2(DEPTH+1)-1:0]   count,
    output logic [$clog2(DEPTH)-1:0]     shift_idx,
    output logic [5:0]                   pos,
    output logic [TAG_BITS-1:0]          key_tag,
    output logic [3:0]                   key_list,
    output logic [ID_BITS-1:0]           key_id,
    // carry out of cell zero
    input  logic                         hit_found,
    input  logic [$clog2(DEPTH)-1:0]     hit_idx,
    input  logic [TAG_BITS-1:0]          hit_tag,
    input  logic [3:0]                   hit_list,
    input  logic [ID_BITS-1:0]           hit_id
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL      = CNT_W'(DEPTH);
    localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(DEPTH - 1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] scan_reg,  scan_next;
    in_word_t         req_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             rsp_valid_reg, rsp_valid_next;
    out_word_t        rsp_reg, rsp_next;

    logic     out_free;
    logic     scan_run;
    logic     apply;
    logic     do_write;
    logic     do_shift;
    logic     needs_scan;
    action_t  act;

    assign out_free = !rsp_valid_reg || rsp_ready;
    assign act      = action_t'(req_reg.action);

    // Actions that search the cells
    always_comb
    begin
        case (req.action) inside
            ACT_REMOVE_POS, ACT_REMOVE_TAG, ACT_REMOVE_KEY, ACT_READ: needs_scan = 1'b1;
            default:                                                  needs_scan = 1'b0;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                    state_next = needs_scan ? ST_SCAN : ST_DONE;
            end
            ST_SCAN:
            begin
                if (scan_reg == SCAN_LAST)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        req_ready = 1'b0;
        scan_run  = 1'b0;
        apply     = 1'b0;
        unique case (state_reg)
            ST_IDLE: req_ready = 1'b1;
            ST_SCAN: scan_run  = 1'b1;
            ST_DONE: apply     = out_free;
            default: req_ready = 1'b0;
        endcase
    end

    // Advance the scan timer
    always_comb
    begin
        if (state_reg == ST_IDLE)
            scan_next = '0;
        else if (scan_run)
            scan_next = scan_reg + IDX_W'(1);
        else
            scan_next = scan_reg;
    end

    // Decode the action into list update and response word
    always_comb
    begin
        rsp_next   = '0;
        count_next = count_reg;
        do_write   = 1'b0;
        do_shift   = 1'b0;
        unique case (act) inside
            ACT_APPEND:
            begin
                if (count_reg < FULL)
                begin
                    rsp_next.ok = 1'b1;
                    count_next  = count_reg + CNT_W'(1);
                    do_write    = 1'b1;
                end
            end
            ACT_REMOVE_POS, ACT_REMOVE_TAG, ACT_REMOVE_KEY:
            begin
                if (hit_found)
                begin
                    rsp_next.ok           = 1'b1;
                    rsp_next.hit_position = 6'(hit_idx);
                    count_next            = count_reg - CNT_W'(1);
                    do_shift              = 1'b1;
                end
            end
            ACT_READ:
            begin
                if (hit_found)
                begin
                    rsp_next.ok               = 1'b1;
                    rsp_next.read_tag         = 16'(hit_tag);
                    rsp_next.read_list_number = hit_list;
                    rsp_next.read_item_id     = 16'(hit_id);
                end
            end
            ACT_CLEAR:
            begin
                rsp_next.ok = 1'b1;
                count_next  = '0;
            end
            default:
            begin
                rsp_next.ok = 1'b0;
            end
        endcase
        rsp_next.entry_count = 7'(count_next);
    end

    // Hold the response until taken
    always_comb
    begin
        if (apply)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            rsp_valid_reg <= rsp_valid_next;
            if (apply)
                count_reg <= count_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            req_reg <= req;
        if (apply)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign ctl.action = req_reg.action;
    assign ctl.write  = apply && do_write;
    assign ctl.shift  = apply && do_shift;
    assign count      = count_reg;
    assign shift_idx  = hit_idx;
    assign pos        = req_reg.position;
    assign key_tag    = TAG_BITS'(req_reg.tag);
    assign key_list   = req_reg.list_number;
    assign key_id     = ID_BITS'(req_reg.item_id);

endmodule

FILE: hw/rtl/cel_checker.sv
// Port-level checks for the compacting entry list, bound to the top level.
module cel_checker
    import cel_pkg::*;
#(
    parameter int DEPTH = CEL_DEPTH
)
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_ready,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input out_word_t rsp
);

    // No response is pending once reset has been applied at an edge
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !rsp_valid)
        else $error("response valid after reset");

    // A failed action reports no position and no read data
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.ok |-> rsp.hit_position == 6'd0 && rsp.read_tag == 16'd0
            && rsp.read_list_number == 4'd0 && rsp.read_item_id == 16'd0)
        else $error("failed action carries nonzero result fields");

    // The count never exceeds the list size
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (DEPTH > 127) || (int'(rsp.entry_count) <= DEPTH))
        else $error("entry count beyond list size");

    // One request at a time: busy right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous one in flight");

    // A stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("stalled response word changed or dropped");

endmodule

bind compacting_entry_list_top cel_checker #(.DEPTH(DEPTH)) u_cel_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
